[rtl/rrh_pkg.sv]
// Shared types and constants for the ROI color histogram.
// No dependencies; imported by roi_rgb_histogram.
`default_nettype none

package rrh_pkg;

  // item kinds carried in s_axis_tuser
  localparam logic [1:0] FUNC_PIXEL = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // register indexes on the configuration port
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] REG_ROI_LEFT     = 3'd2;
  localparam logic [2:0] REG_ROI_TOP      = 3'd3;
  localparam logic [2:0] REG_ROI_WIDTH    = 3'd4;
  localparam logic [2:0] REG_ROI_HEIGHT   = 3'd5;

  localparam int MAX_DIM          = 4096;
  localparam int BINS_PER_CHANNEL = 8;
  localparam int CHAN_BITS        = $clog2(BINS_PER_CHANNEL);
  localparam int TOTAL_BINS       = BINS_PER_CHANNEL * BINS_PER_CHANNEL * BINS_PER_CHANNEL;
  localparam int BIN_AW           = $clog2(TOTAL_BINS);

  localparam int CNT_W     = 25;
  localparam int FRAC_W    = 17;
  localparam int DIV_STEPS = FRAC_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] COUNT_CAP = CNT_W'(16777216);

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

endpackage

`default_nettype wire

[rtl/roi_rgb_histogram.sv]
// Top level: 512-bin RGB histogram over a clipped rectangle, with APB registers.
// Holds the bin memory, the read-modify-write pipeline and a serial divider.
// Depends on rrh_pkg.
// Pixel items: one per cycle while input is not held off; a bin update is written in the
//   cycle after acceptance, with the last write forwarded to the next read of the same bin.
// Read items: the bin count is read, then divided (one quotient bit per cycle in the
//   divider); no new item is taken until the result is registered.
// Clear items and reset: a sweep writes zero to all 512 bins, one per cycle; input is
//   held off until the sweep ends. Registers reset to 640, 480, 1, 1, 0, 0.
`default_nettype none

module roi_rgb_histogram
  import rrh_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // column[12:0], row[25:13], red[33:26], green[41:34], blue[49:42], bin_index[58:50]
  input  wire logic [63:0] s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // result items
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // bin_count[24:0], bin_fraction[41:25], region_area[66:42]
  output logic [71:0]      m_axis_tdata,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // ---------------------------------------------------------------- registers
  logic [12:0] image_width_q, image_height_q;
  logic [13:0] roi_left_q, roi_top_q, roi_width_q, roi_height_q;
  logic        cfg_we;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 13'd640;
      image_height_q <= 13'd480;
      roi_left_q     <= 14'd1;
      roi_top_q      <= 14'd1;
      roi_width_q    <= 14'd0;
      roi_height_q   <= 14'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_IMAGE_WIDTH:  image_width_q  <= pwdata[12:0];
        REG_IMAGE_HEIGHT: image_height_q <= pwdata[12:0];
        REG_ROI_LEFT:     roi_left_q     <= pwdata[13:0];
        REG_ROI_TOP:      roi_top_q      <= pwdata[13:0];
        REG_ROI_WIDTH:    roi_width_q    <= pwdata[13:0];
        REG_ROI_HEIGHT:   roi_height_q   <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_IMAGE_WIDTH:  prdata = {19'd0, image_width_q};
      REG_IMAGE_HEIGHT: prdata = {19'd0, image_height_q};
      REG_ROI_LEFT:     prdata = {18'd0, roi_left_q};
      REG_ROI_TOP:      prdata = {18'd0, roi_top_q};
      REG_ROI_WIDTH:    prdata = {18'd0, roi_width_q};
      REG_ROI_HEIGHT:   prdata = {18'd0, roi_height_q};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- helpers
  function automatic logic in_span(input logic [12:0] pos, input logic [13:0] start,
                                   input logic [13:0] len, input logic [12:0] limit);
    logic signed [15:0] s, l, lo, hi, lim, p;
    s   = $signed({{2{start[13]}}, start});
    l   = $signed({{2{len[13]}}, len});
    p   = $signed({3'd0, pos});
    lo  = (s < 16'sd1) ? 16'sd1 : s;
    hi  = s + l - 16'sd1;
    lim = (limit > 13'(MAX_DIM)) ? 16'(MAX_DIM) : $signed({3'd0, limit});
    if (hi > lim) hi = lim;
    return (p >= lo) && (p <= hi);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v >= COUNT_CAP) ? COUNT_CAP : v + CNT_W'(1);
  endfunction

  // ---------------------------------------------------------------- stage 0
  logic        s_accept;
  logic [1:0]  in_func;
  logic [12:0] in_col, in_row;
  logic [7:0]  in_red, in_green, in_blue;
  logic [8:0]  in_bin;
  logic        in_hit;
  logic [BIN_AW-1:0] pix_addr, rd_addr;

  assign in_func  = s_axis_tuser;
  assign in_col   = s_axis_tdata[12:0];
  assign in_row   = s_axis_tdata[25:13];
  assign in_red   = s_axis_tdata[33:26];
  assign in_green = s_axis_tdata[41:34];
  assign in_blue  = s_axis_tdata[49:42];
  assign in_bin   = s_axis_tdata[58:50];

  assign in_hit = !roi_width_q[13] && (roi_width_q != 14'd0) &&
                  !roi_height_q[13] && (roi_height_q != 14'd0) &&
                  in_span(in_col, roi_left_q, roi_width_q, image_width_q) &&
                  in_span(in_row, roi_top_q, roi_height_q, image_height_q);

  // bin = r + 8*g + 64*b from the top bits of each channel
  assign pix_addr = {in_blue[7 -: CHAN_BITS], in_green[7 -: CHAN_BITS],
                     in_red[7 -: CHAN_BITS]};
  assign rd_addr  = (in_func == FUNC_READ) ? in_bin[BIN_AW-1:0] : pix_addr;

  assign s_accept = s_axis_tvalid & s_axis_tready;

  // ---------------------------------------------------------------- memory
  logic [CNT_W-1:0]  mem [TOTAL_BINS];
  logic [CNT_W-1:0]  rdata_q;
  logic              mem_we;
  logic [BIN_AW-1:0] mem_waddr;
  logic [CNT_W-1:0]  mem_wdata;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[rd_addr];
  end

  // ---------------------------------------------------------------- stage 1
  logic              s1_valid_q;
  logic [1:0]        s1_func_q;
  logic              s1_hit_q;
  logic [BIN_AW-1:0] s1_addr_q;
  logic              wr_valid_q;
  logic [BIN_AW-1:0] wr_addr_q;
  logic [CNT_W-1:0]  wr_data_q;
  logic [CNT_W-1:0]  cur_count;
  logic              s1_pix_wr, s1_read, s1_clear;
  logic              clr_busy_q;
  logic [BIN_AW-1:0] clr_cnt_q;
  logic [CNT_W-1:0]  area_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_func_q <= in_func;
      s1_hit_q  <= in_hit;
      s1_addr_q <= rd_addr;
    end
  end

  // the write at the read edge is not in rdata_q yet: take it from wr_q
  assign cur_count = (wr_valid_q && (wr_addr_q == s1_addr_q)) ? wr_data_q : rdata_q;

  assign s1_pix_wr = s1_valid_q && (s1_func_q == FUNC_PIXEL) && s1_hit_q;
  assign s1_read   = s1_valid_q && (s1_func_q == FUNC_READ);
  assign s1_clear  = s1_valid_q && (s1_func_q == FUNC_CLEAR);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = s1_addr_q;
    mem_wdata = sat_inc(cur_count);
    if (clr_busy_q) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
      mem_wdata = '0;
    end else if (s1_pix_wr) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_valid_q <= 1'b0;
    end else begin
      wr_valid_q <= mem_we;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= mem_waddr;
    wr_data_q <= mem_wdata;
  end

  // clearing sweep, started by reset and by a clear item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
      area_q     <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_cnt_q <= clr_cnt_q + BIN_AW'(1);
        if (clr_cnt_q == BIN_AW'(TOTAL_BINS - 1)) clr_busy_q <= 1'b0;
      end else if (s1_clear) begin
        clr_busy_q <= 1'b1;
        clr_cnt_q  <= '0;
      end
      if (s1_clear) begin
        area_q <= '0;
      end else if (s1_pix_wr) begin
        area_q <= sat_inc(area_q);
      end
    end
  end

  // ---------------------------------------------------------------- divider
  // restoring division of count * 2^16 by area; count never exceeds area
  div_state_e        div_state_q, div_state_d;
  logic [CNT_W-1:0]  div_rem_q, div_rem_d;
  logic [FRAC_W-1:0] div_quo_q, div_quo_d;
  logic [STEP_W-1:0] div_step_q, div_step_d;
  logic [CNT_W-1:0]  div_cnt_q, div_cnt_d;
  logic [CNT_W:0]    div_trial;
  logic              div_ge;
  logic [CNT_W:0]    div_diff;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;
  logic [FRAC_W-1:0] out_frac_q, out_frac_d;
  logic [CNT_W-1:0]  out_area_q, out_area_d;
  logic              out_free;

  assign out_free = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= DIV_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      div_state_q <= div_state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q   <= div_rem_d;
    div_quo_q   <= div_quo_d;
    div_step_q  <= div_step_d;
    div_cnt_q   <= div_cnt_d;
    out_count_q <= out_count_d;
    out_frac_q  <= out_frac_d;
    out_area_q  <= out_area_d;
  end

  always_comb begin
    div_state_d = div_state_q;
    div_rem_d   = div_rem_q;
    div_quo_d   = div_quo_q;
    div_step_d  = div_step_q;
    div_cnt_d   = div_cnt_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_count_d = out_count_q;
    out_frac_d  = out_frac_q;
    out_area_d  = out_area_q;

    // first step compares unshifted for the integer bit, later ones shift in a zero
    div_trial = (div_step_q == '0) ? {1'b0, div_rem_q} : {div_rem_q, 1'b0};
    div_ge    = div_trial >= {1'b0, area_q};
    div_diff  = div_trial - {1'b0, area_q};

    case (div_state_q)
      DIV_IDLE: begin
        if (s1_read) begin
          div_rem_d   = cur_count;
          div_cnt_d   = cur_count;
          div_quo_d   = '0;
          div_step_d  = '0;
          div_state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        div_rem_d  = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
        div_quo_d  = {div_quo_q[FRAC_W-2:0], div_ge};
        div_step_d = div_step_q + STEP_W'(1);
        if (div_step_q == STEP_W'(DIV_STEPS - 1)) div_state_d = DIV_DONE;
      end
      DIV_DONE: begin
        // hold the result until the output register can take it
        if (out_free) begin
          out_valid_d = 1'b1;
          out_count_d = div_cnt_q;
          out_frac_d  = (area_q == '0) ? '0 : div_quo_q;
          out_area_d  = area_q;
          div_state_d = DIV_IDLE;
        end
      end
      default: div_state_d = DIV_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- ports
  assign s_axis_tready = !clr_busy_q && (div_state_q == DIV_IDLE) && !s1_read && !s1_clear;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_area_q, out_frac_q, out_count_q};

endmodule

`default_nettype wire
